### src/pidaw_pkg.sv
// Types, constants and saturating arithmetic helpers for the PID controller core.
package pidaw_pkg;

  localparam int VW   = 32;
  localparam int TW   = 24;
  localparam int FRAC = 16;
  localparam int DW   = (TW > 21) ? TW : 21;
  localparam int CW   = $clog2(VW);
  localparam int IW   = 3;

  typedef logic signed [VW-1:0] val_t;

  localparam val_t V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam val_t V_MIN = {1'b1, {(VW-1){1'b0}}};

  localparam logic [VW-1:0] DEV_SCALE = VW'(1000000);
  localparam logic [DW-1:0] INT_SCALE = DW'(2000000);
  localparam logic [TW-1:0] US_DEFAULT = TW'(1000);
  localparam logic [CW-1:0] CNT_LAST = CW'(VW - 1);

  localparam logic [1:0] REQ_SAMPLE     = 2'd0;
  localparam logic [1:0] REQ_SET_TARGET = 2'd1;
  localparam logic [1:0] REQ_CLEAR      = 2'd2;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_HIGH = 2'd1;
  localparam logic [1:0] CLAMP_LOW  = 2'd2;

  localparam logic [IW-1:0] REG_GAIN_P  = 3'd0;
  localparam logic [IW-1:0] REG_GAIN_I  = 3'd1;
  localparam logic [IW-1:0] REG_GAIN_D  = 3'd2;
  localparam logic [IW-1:0] REG_OUT_MAX = 3'd3;
  localparam logic [IW-1:0] REG_OUT_MIN = 3'd4;

  typedef struct packed {
    logic [1:0]    req_type;
    val_t          measurement;
    val_t          new_target;
    logic [TW-1:0] elapsed_us;
  } pidaw_in_t;

  typedef struct packed {
    val_t       drive;
    logic [1:0] clamp_state;
  } pidaw_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_DEV,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DEV_DONE,
    ST_INT_DONE,
    ST_INT_ADD,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM1,
    ST_SUM2,
    ST_CLAMP,
    ST_FIN
  } pidaw_state_t;

  function automatic logic [VW-1:0] mag(input val_t v);
    mag = v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      sat_add = s[VW] ? V_MIN : V_MAX;
    end else begin
      sat_add = s[VW-1:0];
    end
  endfunction

  function automatic val_t sat_sub(input val_t a, input val_t b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      sat_sub = s[VW] ? V_MIN : V_MAX;
    end else begin
      sat_sub = s[VW-1:0];
    end
  endfunction

  // signed value from magnitude; big flags a magnitude beyond VW bits
  function automatic val_t sat_mag(input logic neg, input logic big, input logic [VW-1:0] m);
    if (neg) begin
      sat_mag = (big || m > VW'(V_MIN)) ? V_MIN : val_t'(-m);
    end else begin
      sat_mag = (big || m[VW-1]) ? V_MAX : val_t'(m);
    end
  endfunction

  // Q16.16 product from magnitude product; value sign saturates first, gain sign after
  function automatic val_t qmul(input logic [2*VW-1:0] p, input logic v_neg,
                                input logic g_neg);
    val_t t;
    t = sat_mag(v_neg, |p[2*VW-1:VW+FRAC], p[VW+FRAC-1:FRAC]);
    if (g_neg) begin
      qmul = (t == V_MIN) ? V_MAX : -t;
    end else begin
      qmul = t;
    end
  endfunction

endpackage

### src/pid_controller_antiwindup_core.sv
// PID controller core: sequencer around one shared multiplier and a radix-2 divider.
// Sequence: a sample runs two 32-step divisions on the shared divider and five passes
//   through the shared multiplier; a first sample skips the divisions and makes three passes.
// Set-target and clear items complete in the accept cycle; ready stays high.
// A sample holds ready low until its result is registered, which waits while an earlier result is not taken.
// Reset: synchronous; gains 0, limits +/-1.0, history cleared, first sample armed.
module pid_controller_antiwindup_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pidaw_pkg::pidaw_in_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pidaw_pkg::pidaw_out_t         out_data,
  input  logic                          cfg_we,
  input  logic [pidaw_pkg::IW-1:0]      cfg_index,
  input  logic [pidaw_pkg::VW-1:0]      cfg_wdata
);
  import pidaw_pkg::*;

  pidaw_state_t state, state_next;

  val_t gain_p, gain_i, gain_d, out_max, out_min;
  val_t setpoint, integral_acc, prev_error, prev_measurement;
  logic first_sample;

  val_t meas, err, dm, es, dev, ni, term, qp, qi, qd, drive_r;
  logic [1:0] cs_r;
  logic [TW-1:0] us;
  logic [2*VW-1:0] prod, prod_next;
  logic [VW-1:0] mul_a, mul_b;
  logic mul_en;
  logic [DW-1:0] r, r_next, div_c;
  logic [DW:0] r2;
  logic [VW-1:0] dq;
  logic [CW-1:0] cnt;
  logic ovf, div_sel, div_ge;
  logic fin_go;
  val_t int_hi, int_clamp;

  assign in_ready = (state == ST_IDLE);
  assign fin_go = !out_valid || out_ready;

  assign div_c  = div_sel ? INT_SCALE : DW'(us);
  assign r2     = {r, dq[VW-1]};
  assign div_ge = r2 >= {1'b0, div_c};
  assign r_next = div_ge ? DW'(r2 - {1'b0, div_c}) : r2[DW-1:0];

  assign int_hi    = (ni > out_max) ? out_max : ni;
  assign int_clamp = (int_hi < out_min) ? out_min : int_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    mul_en = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_data.req_type == REQ_SAMPLE) state_next = ST_ERR;
      end
      ST_ERR: state_next = first_sample ? ST_MUL_P : ST_MUL_DEV;
      ST_MUL_DEV: begin
        mul_a = mag(dm);
        mul_b = DEV_SCALE;
        mul_en = 1'b1;
        state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (cnt == CNT_LAST) state_next = div_sel ? ST_INT_DONE : ST_DEV_DONE;
      end
      ST_DEV_DONE: begin
        mul_a = mag(es);
        mul_b = VW'(us);
        mul_en = 1'b1;
        state_next = ST_DIV_LOAD;
      end
      ST_INT_DONE: state_next = ST_INT_ADD;
      ST_INT_ADD: state_next = ST_MUL_P;
      ST_MUL_P: begin
        mul_a = mag(gain_p);
        mul_b = mag(err);
        mul_en = 1'b1;
        state_next = ST_MUL_I;
      end
      ST_MUL_I: begin
        mul_a = mag(gain_i);
        mul_b = mag(ni);
        mul_en = 1'b1;
        state_next = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_a = mag(gain_d);
        mul_b = mag(dev);
        mul_en = 1'b1;
        state_next = ST_SUM1;
      end
      ST_SUM1: state_next = ST_SUM2;
      ST_SUM2: state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_FIN;
      ST_FIN: begin
        if (fin_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    prod_next = (2*VW)'(mul_a) * (2*VW)'(mul_b);
  end

  // architectural state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
      out_max <= val_t'(65536);
      out_min <= val_t'(-65536);
      setpoint <= '0;
      integral_acc <= '0;
      prev_error <= '0;
      prev_measurement <= '0;
      first_sample <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:  gain_p <= cfg_wdata;
          REG_GAIN_I:  gain_i <= cfg_wdata;
          REG_GAIN_D:  gain_d <= cfg_wdata;
          REG_OUT_MAX: out_max <= cfg_wdata;
          REG_OUT_MIN: out_min <= cfg_wdata;
          default: ;
        endcase
      end
      if (state == ST_IDLE && in_valid) begin
        case (in_data.req_type)
          REQ_SET_TARGET: begin
            if (in_data.new_target != setpoint) begin
              setpoint <= in_data.new_target;
              prev_error <= sat_sub(in_data.new_target, prev_measurement);
            end
          end
          REQ_CLEAR: begin
            integral_acc <= '0;
            prev_error <= '0;
            prev_measurement <= '0;
            first_sample <= 1'b1;
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != ST_FIN) out_valid <= 1'b0;
      if (state == ST_FIN && fin_go) begin
        out_valid <= 1'b1;
        prev_error <= err;
        prev_measurement <= meas;
        integral_acc <= int_clamp;
        first_sample <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (mul_en) prod <= prod_next;
    case (state)
      ST_IDLE: begin
        meas <= in_data.measurement;
        us <= (in_data.elapsed_us == '0) ? US_DEFAULT : in_data.elapsed_us;
      end
      ST_ERR: begin
        err <= sat_sub(setpoint, meas);
        dm <= sat_sub(prev_measurement, meas);
        dev <= '0;
        ni <= integral_acc;
      end
      ST_MUL_DEV: begin
        es <= sat_add(err, prev_error);
        div_sel <= 1'b0;
      end
      ST_DIV_LOAD: begin
        ovf <= prod[2*VW-1:VW] >= VW'(div_c);
        r <= prod[VW+DW-1:VW];
        dq <= prod[VW-1:0];
        cnt <= '0;
      end
      ST_DIV_RUN: begin
        r <= r_next;
        dq <= {dq[VW-2:0], div_ge};
        cnt <= cnt + CW'(1);
      end
      ST_DEV_DONE: begin
        dev <= sat_mag(dm[VW-1], ovf, dq);
        div_sel <= 1'b1;
      end
      ST_INT_DONE: term <= sat_mag(es[VW-1], ovf, dq);
      ST_INT_ADD: ni <= sat_add(integral_acc, term);
      ST_MUL_I: qp <= qmul(prod, err[VW-1], gain_p[VW-1]);
      ST_MUL_D: qi <= qmul(prod, ni[VW-1], gain_i[VW-1]);
      ST_SUM1: begin
        qd <= qmul(prod, dev[VW-1], gain_d[VW-1]);
        drive_r <= sat_add(qp, qi);
      end
      ST_SUM2: drive_r <= sat_add(drive_r, qd);
      ST_CLAMP: begin
        if (drive_r > out_max) begin
          drive_r <= out_max;
          cs_r <= CLAMP_HIGH;
          if (err > 0) ni <= integral_acc;
        end else if (drive_r < out_min) begin
          drive_r <= out_min;
          cs_r <= CLAMP_LOW;
          if (err < 0) ni <= integral_acc;
        end else begin
          cs_r <= CLAMP_NONE;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_data.drive <= drive_r;
          out_data.clamp_state <= cs_r;
        end
      end
      default: ;
    endcase
  end

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.req_type == REQ_SAMPLE |=> !in_ready)
    else $error("ready stayed high after a sample beat");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV_RUN && cnt == CNT_LAST |=> state != ST_DIV_RUN)
    else $error("divider ran past its last step");

  a_clamp_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clamp_state == CLAMP_HIGH |-> out_data.drive == out_max)
    else $error("high clamp without drive at upper limit");

  a_clamp_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clamp_state == CLAMP_LOW |-> out_data.drive == out_min)
    else $error("low clamp without drive at lower limit");

  a_within: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clamp_state == CLAMP_NONE
      |-> out_data.drive <= out_max && out_data.drive >= out_min)
    else $error("unclamped drive outside limits");

  a_first_cleared: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && fin_go |=> !first_sample && out_valid)
    else $error("sample finished without result or history update");

endmodule

### test/pid_controller_antiwindup_core_test.sv
// Self-checking testbench for the PID controller core, with a scoreboard and random stimulus.
`timescale 1ns / 1ps

module pid_controller_antiwindup_core_test;
  import pidaw_pkg::*;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam val_t ONE = 32'sd65536;
  localparam int SETTLE_CYCLES = 100;
  localparam int LIMIT = 1000000;

  class pid_tracker;
    longint gain_p, gain_i, gain_d, lim_hi, lim_lo;
    longint target, integ, last_err, last_meas;
    bit fresh;
    pidaw_out_t drive_due[$];
    int errors;

    function new();
      gain_p = 0;
      gain_i = 0;
      gain_d = 0;
      lim_hi = 65536;
      lim_lo = -65536;
      target = 0;
      integ = 0;
      last_err = 0;
      last_meas = 0;
      fresh = 1'b1;
      errors = 0;
    endfunction

    function longint clip(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    // a * b / c on magnitudes, truncated toward zero
    function longint scale(longint a, longint unsigned b, longint unsigned c);
      longint unsigned m;
      m = (a < 0) ? -a : a;
      m = m * b / c;
      return clip((a < 0) ? -longint'(m) : longint'(m));
    endfunction

    function longint gain_term(longint g, longint v);
      longint p;
      p = scale(v, (g < 0) ? -g : g, 65536);
      return (g < 0) ? clip(-p) : p;
    endfunction

    function void set_reg(logic [IW-1:0] idx, val_t v);
      case (idx)
        REG_GAIN_P:  gain_p = longint'(v);
        REG_GAIN_I:  gain_i = longint'(v);
        REG_GAIN_D:  gain_d = longint'(v);
        REG_OUT_MAX: lim_hi = longint'(v);
        REG_OUT_MIN: lim_lo = longint'(v);
        default: ;
      endcase
    endfunction

    function int pending();
      return drive_due.size();
    endfunction

    function void note_item(pidaw_in_t it);
      longint meas, tgt, err, dev, ni, drv;
      longint unsigned us;
      pidaw_out_t res;
      meas = longint'(it.measurement);
      tgt = longint'(it.new_target);
      case (it.req_type)
        REQ_SET_TARGET: begin
          if (tgt != target) begin
            target = tgt;
            last_err = clip(target - last_meas);
          end
        end
        REQ_CLEAR: begin
          integ = 0;
          last_err = 0;
          last_meas = 0;
          fresh = 1'b1;
        end
        REQ_SAMPLE: begin
          us = 64'(it.elapsed_us);
          if (us == 0) us = 1000;
          err = clip(target - meas);
          dev = 0;
          ni = integ;
          if (!fresh) begin
            dev = scale(clip(last_meas - meas), 1000000, us);
            ni = clip(integ + scale(clip(err + last_err), us, 2000000));
          end else begin
            fresh = 1'b0;
          end
          drv = clip(gain_term(gain_p, err) + gain_term(gain_i, ni));
          drv = clip(drv + gain_term(gain_d, dev));
          res.clamp_state = CLAMP_NONE;
          if (drv > lim_hi) begin
            drv = lim_hi;
            res.clamp_state = CLAMP_HIGH;
            if (err > 0) ni = integ;
          end else if (drv < lim_lo) begin
            drv = lim_lo;
            res.clamp_state = CLAMP_LOW;
            if (err < 0) ni = integ;
          end
          last_err = err;
          last_meas = meas;
          integ = ni;
          if (integ > lim_hi) integ = lim_hi;
          if (integ < lim_lo) integ = lim_lo;
          res.drive = val_t'(drv);
          drive_due.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void miss(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_drive(pidaw_out_t got);
      pidaw_out_t want;
      if (drive_due.size() == 0) begin
        miss($sformatf("result with none expected: drive %0d clamp %0d",
                       got.drive, got.clamp_state));
      end else begin
        want = drive_due.pop_front();
        if (got.drive !== want.drive)
          miss($sformatf("drive: expected %0d, got %0d", want.drive, got.drive));
        if (got.clamp_state !== want.clamp_state)
          miss($sformatf("clamp_state: expected %0d, got %0d",
                         want.clamp_state, got.clamp_state));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  pidaw_in_t in_data;
  logic out_valid;
  logic out_ready;
  pidaw_out_t out_data;
  logic cfg_we;
  logic [IW-1:0] cfg_index;
  logic [VW-1:0] cfg_wdata;

  pid_tracker trk = new();
  int cycles = 0;
  int tx_calm = 0;
  int rx_hold = 0;
  int rx_calm = 0;

  pid_controller_antiwindup_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) trk.note_item(in_data);
      if (out_valid && out_ready) trk.check_drive(out_data);
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 15);
    return $urandom_range(20, 100);
  endfunction

  function automatic int tx_gap();
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    if ($urandom_range(0, 99) == 0) tx_calm = $urandom_range(20, 60);
    if ($urandom_range(0, 1) == 0) return 0;
    return pick_pause();
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_calm > 0) begin
        rx_calm--;
      end else if ($urandom_range(0, 199) == 0) begin
        rx_calm = $urandom_range(50, 300);
      end else if ($urandom_range(0, 3) == 0) begin
        rx_hold = pick_pause();
      end
    end
  end

  function automatic pidaw_in_t mk(logic [1:0] kind, val_t meas, val_t tgt,
                                   logic [TW-1:0] us);
    pidaw_in_t it;
    it.req_type = kind;
    it.measurement = meas;
    it.new_target = tgt;
    it.elapsed_us = us;
    return it;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input pidaw_in_t it, input int gap);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (trk.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input val_t v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    trk.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic program_regs(input val_t gp, input val_t gi, input val_t gd,
                              input val_t hi, input val_t lo);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_OUT_MAX, hi);
    write_reg(REG_OUT_MIN, lo);
    cfg_we <= 1'b0;
  endtask

  function automatic pidaw_in_t random_item();
    pidaw_in_t it;
    int r;
    val_t base;
    it = mk(REQ_SAMPLE, $urandom, $urandom, TW'($urandom));
    base = val_t'(trk.target);
    r = $urandom_range(0, 99);
    if (r < 72) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        it.measurement = base + ($signed($urandom) >>> $urandom_range(6, 22));
      end else if (r == 8) begin
        case ($urandom_range(0, 3))
          0: it.measurement = V_MAX;
          1: it.measurement = V_MIN;
          2: it.measurement = '0;
          default: it.measurement = base;
        endcase
      end
      r = $urandom_range(0, 9);
      if (r < 5) it.elapsed_us = TW'($urandom_range(1, 2000));
      else if (r < 7) it.elapsed_us = '0;
      else if (r == 7) it.elapsed_us = TW'($urandom_range(1, 8));
    end else if (r < 86) begin
      it.req_type = REQ_SET_TARGET;
      r = $urandom_range(0, 9);
      if (r < 2) it.new_target = base;
      else if (r < 7) it.new_target = $signed($urandom) >>> $urandom_range(8, 18);
    end else if (r < 93) begin
      it.req_type = REQ_CLEAR;
    end else begin
      it.req_type = REQ_UNUSED;
    end
    return it;
  endfunction

  task automatic run_random(input int n);
    int done;
    pidaw_in_t it;
    done = 0;
    while (done < n) begin
      it = random_item();
      if (it.req_type != REQ_UNUSED) done++;
      if ($urandom_range(0, 59) == 0) begin
        send_item(it, 1);
        drain();
      end else begin
        send_item(it, tx_gap());
      end
    end
  endtask

  function automatic val_t small_rand(int lo_shift, int hi_shift);
    return $signed($urandom) >>> $urandom_range(lo_shift, hi_shift);
  endfunction

  initial begin
    val_t a, b;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    program_regs(ONE, ONE / 2, 32'sd655, 10 * ONE, -10 * ONE);
    send_item(mk(REQ_SAMPLE, '0, $urandom, '0), tx_gap());
    send_item(mk(REQ_SET_TARGET, $urandom, 5 * ONE, TW'($urandom)), tx_gap());
    send_item(mk(REQ_SET_TARGET, $urandom, 5 * ONE, TW'($urandom)), tx_gap());
    send_item(mk(REQ_SAMPLE, ONE, $urandom, '0), tx_gap());
    send_item(mk(REQ_SAMPLE, V_MAX, $urandom, 24'd1), tx_gap());
    send_item(mk(REQ_SAMPLE, V_MIN, $urandom, 24'hFFFFFF), tx_gap());
    send_item(mk(REQ_SAMPLE, -32'sd1, $urandom, 24'd1), tx_gap());
    send_item(mk(REQ_UNUSED, $urandom, $urandom, TW'($urandom)), tx_gap());
    send_item(mk(REQ_CLEAR, $urandom, $urandom, TW'($urandom)), tx_gap());
    send_item(mk(REQ_SAMPLE, 2 * ONE, $urandom, 24'd500), tx_gap());
    send_item(mk(REQ_SAMPLE, 3 * ONE, $urandom, 24'd1000), tx_gap());
    send_item(mk(REQ_SET_TARGET, $urandom, V_MAX, TW'($urandom)), tx_gap());
    send_item(mk(REQ_SAMPLE, V_MIN, $urandom, 24'h800000), tx_gap());
    send_item(mk(REQ_SAMPLE, V_MIN, $urandom, 24'd1000), tx_gap());
    send_item(mk(REQ_SET_TARGET, $urandom, V_MIN, TW'($urandom)), tx_gap());
    send_item(mk(REQ_SAMPLE, V_MAX, $urandom, 24'd1000), tx_gap());
    send_item(mk(REQ_SAMPLE, V_MAX, $urandom, '0), tx_gap());
    send_item(mk(REQ_SET_TARGET, $urandom, '0, TW'($urandom)), tx_gap());
    send_item(mk(REQ_SAMPLE, '0, $urandom, 24'd1000), tx_gap());
    send_item(mk(REQ_SAMPLE, ONE / 2, $urandom, 24'd2000), tx_gap());

    program_regs(2 * ONE, 3 * ONE / 2, 32'sd1311, 20 * ONE, -20 * ONE);
    run_random(94);
    program_regs(V_MAX, V_MAX, V_MAX, V_MAX, V_MIN);
    run_random(94);
    program_regs(V_MIN, V_MIN, V_MIN, ONE, -ONE);
    run_random(94);
    // inverted limits
    program_regs(ONE / 2, 4 * ONE, 32'sd66, -2 * ONE, 3 * ONE);
    run_random(94);
    program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(94);
    program_regs('0, '0, '0, '0, '0);
    run_random(94);
    a = small_rand(4, 12);
    b = small_rand(4, 12);
    program_regs(small_rand(8, 16), small_rand(8, 16), small_rand(8, 16),
                 (a > b) ? a : b, (a > b) ? b : a);
    run_random(94);
    program_regs(-ONE, 8 * ONE, -32'sd6554, ONE / 4, -3 * ONE / 4);
    run_random(94);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (trk.errors == 0 && trk.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/pidaw_pkg.sv
src/pid_controller_antiwindup_core.sv
test/pid_controller_antiwindup_core_test.sv
